// ===== sv/tpfc_pkg.sv =====
// tpfc_pkg: shared widths, field positions, register codes and reset values
// for the touch point filter and calibration core. No dependencies.
package tpfc_pkg;

  localparam int NUM_SAMPLES     = 5;
  localparam int SAMPLE_W        = 12;
  localparam int COORD_W         = 16;
  localparam int SCALE_W         = 24;
  localparam int OFFSET_W        = 16;
  localparam int SCALE_FRAC_BITS = 16;

  // trimmed mean: sum of five, minus min and max, divided by three
  localparam int SUM_W       = SAMPLE_W + 3;
  localparam int TRIM_W      = SAMPLE_W + 2;
  localparam int AVG_W       = SAMPLE_W;
  localparam int RECIP_SHIFT = 16;
  // ceil(2^16 / 3), exact floor for values below 2^15
  localparam int RECIP3      = 21846;
  localparam int RECIP_W     = 15;
  localparam int DIV_PROD_W  = TRIM_W + RECIP_W;

  // calibration sum width
  localparam int PROD_W  = AVG_W + 1 + SCALE_W;
  localparam int SHOFF_W = OFFSET_W + SCALE_FRAC_BITS;
  localparam int T_W     = ((PROD_W > SHOFF_W) ? PROD_W : SHOFF_W) + 1;

  localparam logic [COORD_W-1:0] PEN_UP_COORD = '1;

  // input word layout
  localparam int IN_PEN_BIT    = 0;
  localparam int IN_REARM_BIT  = 1;
  localparam int IN_X_LSB      = 2;
  localparam int IN_Y_LSB      = IN_X_LSB + NUM_SAMPLES * SAMPLE_W;
  localparam int IN_FIELDS_W   = IN_Y_LSB + NUM_SAMPLES * SAMPLE_W;
  localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

  // output word layout
  localparam int OUT_PRESS_BIT = 0;
  localparam int OUT_X_LSB     = 1;
  localparam int OUT_Y_LSB     = OUT_X_LSB + COORD_W;
  localparam int OUT_FIELDS_W  = OUT_Y_LSB + COORD_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SCALE_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CfgScaleX  = 2'd0,
    CfgOffsetX = 2'd1,
    CfgScaleY  = 2'd2,
    CfgOffsetY = 2'd3
  } cfg_reg_e;

  localparam logic signed [SCALE_W-1:0]  SCALE_RESET  = 24'sd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = '0;

  typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_vec_t;

endpackage

// ===== sv/tpfc_trim.sv =====
// tpfc_trim: trimmed mean of five converter samples, min and max dropped,
// middle three averaged with truncation. Uses tpfc_pkg.
module tpfc_trim (
  input  tpfc_pkg::sample_vec_t         samples_i,
  output logic [tpfc_pkg::AVG_W-1:0]    avg_o
);
  import tpfc_pkg::*;

  logic [SUM_W-1:0]      sum;
  logic [SAMPLE_W-1:0]   lo;
  logic [SAMPLE_W-1:0]   hi;
  logic [TRIM_W-1:0]     trim;
  logic [DIV_PROD_W-1:0] div_prod;

  always_comb begin
    sum = '0;
    lo  = '1;
    hi  = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      sum = sum + SUM_W'(samples_i[i]);
      if (samples_i[i] < lo) lo = samples_i[i];
      if (samples_i[i] > hi) hi = samples_i[i];
    end
    trim = TRIM_W'(sum - SUM_W'(lo) - SUM_W'(hi));
  end

  // divide by three through the reciprocal
  assign div_prod = DIV_PROD_W'(trim) * DIV_PROD_W'(RECIP3);
  assign avg_o    = div_prod[RECIP_SHIFT +: AVG_W];

endmodule

// ===== sv/tpfc_map.sv =====
// tpfc_map: linear calibration of one axis, avg * scale / 2^frac + offset,
// clamped to the coordinate range. Uses tpfc_pkg.
module tpfc_map (
  input  logic [tpfc_pkg::AVG_W-1:0]           avg_i,
  input  logic signed [tpfc_pkg::SCALE_W-1:0]  scale_i,
  input  logic signed [tpfc_pkg::OFFSET_W-1:0] offset_i,
  output logic [tpfc_pkg::COORD_W-1:0]         coord_o
);
  import tpfc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [T_W-1:0]    prod_ext;
  logic signed [T_W-1:0]    off_ext;
  logic signed [T_W-1:0]    total;
  logic signed [T_W-1:0]    quot;

  assign prod     = $signed({1'b0, avg_i}) * scale_i;
  assign prod_ext = T_W'(prod);
  assign off_ext  = T_W'(offset_i);
  assign total    = prod_ext + (off_ext <<< SCALE_FRAC_BITS);
  assign quot     = total >>> SCALE_FRAC_BITS;

  always_comb begin
    priority if (total[T_W-1]) begin
      coord_o = '0;
    end else if (|quot[T_W-1:COORD_W]) begin
      coord_o = '1;
    end else begin
      coord_o = quot[COORD_W-1:0];
    end
  end

endmodule

// ===== sv/touch_point_filter_calibrate_core.sv =====
// Touch scan filter and calibration core. Takes one scan word per clock with
// no bubbles unless the result port stalls; each accepted scan word passes
// through three register stages (input word, trimmed means, calibrated
// result). Per axis the smallest and largest of five samples are dropped, the
// middle three averaged, then mapped with a signed Q8.16 scale and pixel
// offset and clamped to 0..65535. One press is reported per pen-down
// (re-armed by pen up or the rearm bit); pen up reports 0xffff coordinates.
// Configuration writes take effect at once and belong to idle periods.
// Depends on tpfc_pkg, tpfc_trim and tpfc_map.
module touch_point_filter_calibrate_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpfc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [tpfc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // pen_down, rearm, x_sample_0..4, y_sample_0..4, zero pad
  input  logic [tpfc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // press_reported, x_pos, y_pos, zero pad
  output logic [tpfc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import tpfc_pkg::*;

  // configuration registers
  logic signed [SCALE_W-1:0]  scale_x_q, scale_y_q;
  logic signed [OFFSET_W-1:0] offset_x_q, offset_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q  <= SCALE_RESET;
      scale_y_q  <= SCALE_RESET;
      offset_x_q <= OFFSET_RESET;
      offset_y_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgScaleX:  scale_x_q  <= cfg_wdata_i;
        CfgOffsetX: offset_x_q <= cfg_wdata_i[OFFSET_W-1:0];
        CfgScaleY:  scale_y_q  <= cfg_wdata_i;
        CfgOffsetY: offset_y_q <= cfg_wdata_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when the next one is empty or moving
  logic en_in, en_mid, en_out;
  logic in_vld_q, mid_vld_q, out_vld_q;

  assign en_out = !out_vld_q || m_axis_tready_i;
  assign en_mid = !mid_vld_q || en_out;
  assign en_in  = !in_vld_q || en_mid;

  assign s_axis_tready_o = en_in;
  assign m_axis_tvalid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_in)  in_vld_q  <= s_axis_tvalid_i;
      if (en_mid) mid_vld_q <= in_vld_q;
      if (en_out) out_vld_q <= mid_vld_q;
    end
  end

  // input register
  sample_vec_t in_x_s, in_y_s;
  sample_vec_t in_x_q, in_y_q;
  logic        in_pen_q, in_rearm_q;

  always_comb begin
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      in_x_s[i] = s_axis_tdata_i[IN_X_LSB + i*SAMPLE_W +: SAMPLE_W];
      in_y_s[i] = s_axis_tdata_i[IN_Y_LSB + i*SAMPLE_W +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && s_axis_tvalid_i) begin
      in_pen_q   <= s_axis_tdata_i[IN_PEN_BIT];
      in_rearm_q <= s_axis_tdata_i[IN_REARM_BIT];
      in_x_q     <= in_x_s;
      in_y_q     <= in_y_s;
    end
  end

  // trimmed means
  logic [AVG_W-1:0] avg_x, avg_y;
  logic [AVG_W-1:0] mid_avg_x_q, mid_avg_y_q;
  logic             mid_pen_q, mid_rearm_q;

  tpfc_trim u_trim_x (.samples_i(in_x_q), .avg_o(avg_x));
  tpfc_trim u_trim_y (.samples_i(in_y_q), .avg_o(avg_y));

  always_ff @(posedge clk_i) begin
    if (en_mid && in_vld_q) begin
      mid_pen_q   <= in_pen_q;
      mid_rearm_q <= in_rearm_q;
      mid_avg_x_q <= avg_x;
      mid_avg_y_q <= avg_y;
    end
  end

  // calibration and press tracking
  logic [COORD_W-1:0] map_x, map_y;
  logic               armed_q, armed_d;
  logic [COORD_W-1:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic               press_d, press_q;
  logic               armed_now;

  tpfc_map u_map_x (
    .avg_i(mid_avg_x_q), .scale_i(scale_x_q), .offset_i(offset_x_q), .coord_o(map_x)
  );
  tpfc_map u_map_y (
    .avg_i(mid_avg_y_q), .scale_i(scale_y_q), .offset_i(offset_y_q), .coord_o(map_y)
  );

  always_comb begin
    armed_now = armed_q || mid_rearm_q;
    // a held pen leaves the detector disarmed, pen up re-arms it
    armed_d   = !mid_pen_q;
    press_d   = mid_pen_q && armed_now;
    held_x_d  = held_x_q;
    held_y_d  = held_y_q;
    if (!mid_pen_q) begin
      held_x_d = PEN_UP_COORD;
      held_y_d = PEN_UP_COORD;
    end else if (armed_now) begin
      held_x_d = map_x;
      held_y_d = map_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b1;
      held_x_q <= PEN_UP_COORD;
      held_y_q <= PEN_UP_COORD;
    end else if (en_out && mid_vld_q) begin
      armed_q  <= armed_d;
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && mid_vld_q) press_q <= press_d;
  end

  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, held_y_q, held_x_q, press_q};

endmodule

// ===== sv/tpfc_checker.sv =====
// tpfc_checker: port-level assertions for the touch filter core, attached by
// the bind below. Uses tpfc_pkg field positions.
module tpfc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [tpfc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tpfc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import tpfc_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // no result word during reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result word valid during reset");

  // input only backs up behind a stalled result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // with the output draining, an accepted word reaches the output through the input, mean and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc ##1 m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word missing after pipeline latency");

  // pen up gives no press and the pen-up coordinates
  a_pen_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tdata_i[IN_PEN_BIT]) ##1 m_axis_tready_i ##1 m_axis_tready_i
    |=> m_axis_tvalid_o && !m_axis_tdata_o[OUT_PRESS_BIT] &&
        m_axis_tdata_o[OUT_X_LSB +: COORD_W] == PEN_UP_COORD &&
        m_axis_tdata_o[OUT_Y_LSB +: COORD_W] == PEN_UP_COORD)
    else $error("pen-up word carries wrong fields");

endmodule

bind touch_point_filter_calibrate_core tpfc_checker u_tpfc_checker (.*);

// ===== tb/tpfc_checker.sv =====
// tpfc_scoreboard: watches the scan, result and configuration ports of the touch
// point filter and calibration core, predicts every result word and compares.
// Depends on tpfc_pkg.
`timescale 1ns / 1ps

module tpfc_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpfc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tpfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // pen_down, rearm, x_sample_0..4, y_sample_0..4, zero pad
  input  logic [tpfc_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // press_reported, x_pos, y_pos, zero pad
  input  logic [tpfc_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                              errors_o,
  output int                              pending_o
);
  import tpfc_pkg::*;

  typedef struct packed {
    logic               press;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } touch_result_t;

  touch_result_t expected_q[$];
  touch_result_t got_word;
  touch_result_t want_word;
  int            mismatch_cnt = 0;

  logic signed [SCALE_W-1:0]  slope_x;
  logic signed [SCALE_W-1:0]  slope_y;
  logic signed [OFFSET_W-1:0] bias_x;
  logic signed [OFFSET_W-1:0] bias_y;
  logic                       armed_q;
  logic [COORD_W-1:0]         held_x;
  logic [COORD_W-1:0]         held_y;

  assign errors_o = mismatch_cnt;

  // drop one smallest and one largest, average the middle three
  function automatic logic [SAMPLE_W-1:0] axis_mean(input sample_vec_t s);
    logic [SUM_W-1:0]    total;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    total = '0;
    lo    = '1;
    hi    = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      total += s[i];
      if (s[i] < lo) lo = s[i];
      if (s[i] > hi) hi = s[i];
    end
    return SAMPLE_W'((total - lo - hi) / 3);
  endfunction

  function automatic logic [COORD_W-1:0] calibrate(input logic [SAMPLE_W-1:0] avg,
                                                   input logic signed [SCALE_W-1:0] slope,
                                                   input logic signed [OFFSET_W-1:0] bias);
    longint acc;
    acc = longint'(avg) * longint'(slope) + (longint'(bias) <<< SCALE_FRAC_BITS);
    if (acc < 0) return '0;
    acc = acc >>> SCALE_FRAC_BITS;
    if (acc > 65535) return '1;
    return COORD_W'(acc);
  endfunction

  function automatic touch_result_t predict_scan(input logic [IN_DATA_W-1:0] w);
    touch_result_t r;
    r.press = 1'b0;
    if (w[IN_REARM_BIT]) armed_q = 1'b1;
    if (w[IN_PEN_BIT]) begin
      if (armed_q) begin
        armed_q = 1'b0;
        held_x  = calibrate(axis_mean(w[IN_X_LSB +: NUM_SAMPLES*SAMPLE_W]), slope_x, bias_x);
        held_y  = calibrate(axis_mean(w[IN_Y_LSB +: NUM_SAMPLES*SAMPLE_W]), slope_y, bias_y);
        r.press = 1'b1;
      end
    end else begin
      armed_q = 1'b1;
      held_x  = PEN_UP_COORD;
      held_y  = PEN_UP_COORD;
    end
    r.x = held_x;
    r.y = held_y;
    return r;
  endfunction

  task automatic flag_field(input string name, input int want, input int got);
    mismatch_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_x = SCALE_RESET;
      slope_y = SCALE_RESET;
      bias_x  = OFFSET_RESET;
      bias_y  = OFFSET_RESET;
      armed_q = 1'b1;
      held_x  = PEN_UP_COORD;
      held_y  = PEN_UP_COORD;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CfgScaleX:  slope_x = cfg_wdata_i;
          CfgOffsetX: bias_x  = cfg_wdata_i[OFFSET_W-1:0];
          CfgScaleY:  slope_y = cfg_wdata_i;
          CfgOffsetY: bias_y  = cfg_wdata_i[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) expected_q.push_back(predict_scan(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got_word.press = m_tdata_i[OUT_PRESS_BIT];
        got_word.x     = m_tdata_i[OUT_X_LSB +: COORD_W];
        got_word.y     = m_tdata_i[OUT_Y_LSB +: COORD_W];
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata_i);
        end else begin
          want_word = expected_q.pop_front();
          if (got_word.press !== want_word.press)
            flag_field("press_reported", want_word.press, got_word.press);
          if (got_word.x !== want_word.x) flag_field("x_pos", want_word.x, got_word.x);
          if (got_word.y !== want_word.y) flag_field("y_pos", want_word.y, got_word.y);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: drives touch scans and calibration writes into the touch point filter
// and calibration core and gives the verdict; checking lives in tpfc_scoreboard.
// Depends on tpfc_pkg, tpfc_scoreboard and the core.
`timescale 1ns / 1ps

module tb_top;
  import tpfc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 180;
  localparam int NUM_PHASES   = 6;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    errors;
  int                    pending;

  int                    burst_left = 0;
  int                    sent_cnt;
  int                    cycle_cnt = 0;
  int                    rx_mode = 0;
  int                    rx_left = 0;
  int                    stall_run = 0;
  int                    cx;
  int                    cy;
  int                    spread;
  int                    n_up;
  int                    n_down;
  logic [SCALE_W-1:0]    sx;
  logic [SCALE_W-1:0]    sy;
  logic [OFFSET_W-1:0]   ox;
  logic [OFFSET_W-1:0]   oy;

  touch_point_filter_calibrate_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  tpfc_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver: stretches of always ready, sparse stalls, or long hold-offs
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
        end
      end
    endcase
  end

  function automatic logic [IN_DATA_W-1:0] pack_scan(input logic pen, input logic rearm,
                                                     input sample_vec_t xs,
                                                     input sample_vec_t ys);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[IN_PEN_BIT]   = pen;
    w[IN_REARM_BIT] = rearm;
    w[IN_X_LSB +: NUM_SAMPLES*SAMPLE_W] = xs;
    w[IN_Y_LSB +: NUM_SAMPLES*SAMPLE_W] = ys;
    return w;
  endfunction

  // samples jittered around a center, now and then a wild outlier
  function automatic sample_vec_t scatter(input int center, input int jitter);
    sample_vec_t s;
    int v;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      v = center + int'($urandom_range(0, 2 * jitter)) - jitter;
      if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 4095);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      s[i] = SAMPLE_W'(v);
    end
    return s;
  endfunction

  task automatic send_scan(input logic [IN_DATA_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // stop the stream and let every outstanding word come back
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // upper write data bits above an offset are don't-care, so fill them randomly
  task automatic set_calibration(input logic [SCALE_W-1:0] scale_x,
                                 input logic [OFFSET_W-1:0] offset_x,
                                 input logic [SCALE_W-1:0] scale_y,
                                 input logic [OFFSET_W-1:0] offset_y);
    cfg_we    <= 1'b1;
    cfg_addr  <= CfgScaleX;
    cfg_wdata <= scale_x;
    @(posedge clk_i);
    cfg_addr  <= CfgOffsetX;
    cfg_wdata <= {8'($urandom), offset_x};
    @(posedge clk_i);
    cfg_addr  <= CfgScaleY;
    cfg_wdata <= scale_y;
    @(posedge clk_i);
    cfg_addr  <= CfgOffsetY;
    cfg_wdata <= {8'($urandom), offset_y};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    int mag;
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return '0;
      default: begin
        mag = $urandom_range(4000, 200000);
        return ($urandom_range(0, 3) == 0) ? SCALE_W'(-mag) : SCALE_W'(mag);
      end
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset(input logic [SCALE_W-1:0] scale);
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: begin
        // a flipped axis needs a positive offset to land on screen
        if (scale[SCALE_W-1]) return OFFSET_W'($urandom_range(100, 32767));
        return OFFSET_W'(int'($urandom_range(0, 4000)) - 2000);
      end
    endcase
  endfunction

  initial begin
    // driven at time zero so the reset edge reaches every asynchronously reset register
    rst_ni <= 1'b0;
    sent_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: pen up, presses at the sample extremes, held pen, rearm
    send_scan(pack_scan(1'b0, 1'b0, '0, '0));
    send_scan(pack_scan(1'b1, 1'b0, '0, '0));
    send_scan(pack_scan(1'b1, 1'b0, '1, '1));
    send_scan(pack_scan(1'b1, 1'b1, '1, '1));
    send_scan(pack_scan(1'b0, 1'b1, '1, '1));
    send_scan(pack_scan(1'b1, 1'b0,
                        {12'd1005, 12'd1001, 12'd1000, 12'd0, 12'd4095},
                        {12'd7, 12'd3000, 12'd7, 12'd7, 12'd7}));
    send_scan(pack_scan(1'b0, 1'b0, '0, '0));
    // equal samples at the trim
    send_scan(pack_scan(1'b1, 1'b0,
                        {12'd4095, 12'd0, 12'd0, 12'd0, 12'd0},
                        {5{12'd2048}}));
    send_scan(pack_scan(1'b0, 1'b0, '1, '0));
    drain();

    // saturation high on x, clamp to zero on y
    set_calibration(24'h7fffff, 16'h7fff, 24'h800000, 16'h8000);
    send_scan(pack_scan(1'b1, 1'b0, '1, '1));
    send_scan(pack_scan(1'b0, 1'b0, '0, '0));
    send_scan(pack_scan(1'b1, 1'b0, '0, '0));
    drain();

    // zero slope with a negative offset, unit lsb slope with the top offset
    set_calibration('0, 16'hffff, 24'h000001, 16'h7fff);
    send_scan(pack_scan(1'b1, 1'b1, '1, '1));
    send_scan(pack_scan(1'b0, 1'b0, '1, '1));
    drain();

    // mirrored x axis
    set_calibration(24'hff0000, 16'd4095, 24'h00c000, 16'd100);
    send_scan(pack_scan(1'b1, 1'b0, scatter(300, 10), scatter(3900, 10)));
    send_scan(pack_scan(1'b1, 1'b1, scatter(3000, 30), scatter(50, 30)));
    send_scan(pack_scan(1'b0, 1'b0, '0, '1));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        set_calibration(SCALE_RESET, OFFSET_RESET, SCALE_RESET, OFFSET_RESET);
      end else begin
        sx = pick_scale();
        sy = pick_scale();
        ox = pick_offset(sx);
        oy = pick_offset(sy);
        set_calibration(sx, ox, sy, oy);
      end
      sent_cnt = 0;
      while (sent_cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise word
          send_scan(pack_scan(1'($urandom), 1'($urandom),
                              scatter($urandom_range(0, 4095), 2048),
                              scatter($urandom_range(0, 4095), 2048)));
        end else begin
          // stroke: a few pen-up scans (sometimes none), then a held touch
          cx     = $urandom_range(0, 4095);
          cy     = $urandom_range(0, 4095);
          spread = ($urandom_range(0, 3) == 0) ? 400 : $urandom_range(0, 25);
          n_up   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
          n_down = $urandom_range(1, 8);
          repeat (n_up) send_scan(pack_scan(1'b0, ($urandom_range(0, 9) == 0),
                                            scatter(cx, 2048), scatter(cy, 2048)));
          repeat (n_down) send_scan(pack_scan(1'b1, ($urandom_range(0, 9) == 0),
                                              scatter(cx, spread), scatter(cy, spread)));
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
